// File: rtl/core/tws_pkg.sv
// Package for the triangle-weighted smoother: sizes, pipeline control type,
// tap weight, weight sum and reciprocal table functions.
// No dependencies.
package tws_pkg;

	localparam int MAX_TAPS    = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int TAP_W       = 5;

	localparam int COUNT_LIMIT = 2 * MAX_TAPS - 1;
	localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);
	localparam int IDX_W       = $clog2(MAX_TAPS);
	localparam int NSEL_W      = $clog2(MAX_TAPS + 1);
	localparam int HALF_W      = $clog2(MAX_TAPS / 2 + 1);
	localparam int WGT_W       = $clog2((MAX_TAPS + 1) / 2 + 1);
	localparam int WSUM_MAX    = ((MAX_TAPS + 2) / 2) * ((MAX_TAPS + 2) / 2);
	localparam int WSUM_W      = $clog2(WSUM_MAX + 1);
	localparam int DIV_W       = WSUM_W + 1;
	localparam int PROD_W      = SAMPLE_BITS + WGT_W;
	localparam int SUM_W       = SAMPLE_BITS + WSUM_W;
	localparam int MAG_W       = SAMPLE_BITS - 1 + WSUM_W;
	localparam int NUM_W       = MAG_W + 2;
	localparam int RCP_SHIFT   = NUM_W + 1;
	localparam int RCP_W       = RCP_SHIFT;
	localparam int MUL_W       = NUM_W + RCP_W;
	localparam int Q_W         = SAMPLE_BITS;
	localparam int GRP         = 4;
	localparam int GROUPS      = (MAX_TAPS + GRP - 1) / GRP;

	typedef logic signed [SAMPLE_BITS-1:0] win_t [MAX_TAPS];
	typedef logic [RCP_W-1:0] recip_tab_t [MAX_TAPS+1];

	typedef struct packed {
		logic                   smooth;
		logic                   edge_raw;
		logic                   last;
		logic [SAMPLE_BITS-1:0] raw;
		logic [NSEL_W-1:0]      taps;
	} ctrl_t;

	function automatic logic [WGT_W-1:0] tap_weight(int unsigned p, logic [NSEL_W-1:0] n);
		int unsigned a;
		int unsigned b;
		a = p + 1;
		b = 0;
		if (p < int'(n))
			b = int'(n) - p;
		return WGT_W'((a < b) ? a : b);
	endfunction

	function automatic logic [WSUM_W-1:0] wsum_of(logic [NSEL_W-1:0] n);
		logic [HALF_W-1:0] h;
		logic [WSUM_W-1:0] hp;
		h  = HALF_W'(n >> 1);
		hp = WSUM_W'(h) + 1'b1;
		if (n[0])
			return WSUM_W'(hp * hp);
		return WSUM_W'(WSUM_W'(h) * hp);
	endfunction

	function automatic recip_tab_t recip_table();
		recip_tab_t tab;
		longint     d;
		longint     r;
		longint     cand;
		for (int n = 0; n <= MAX_TAPS; n++) begin
			d = 2 * longint'(wsum_of(NSEL_W'(n)));
			if (d == 0)
				d = 2;
			r = 0;
			for (int k = RCP_W - 1; k >= 0; k--) begin
				cand = r | (longint'(1) << k);
				if (cand * d <= (longint'(1) << RCP_SHIFT))
					r = cand;
			end
			tab[n] = RCP_W'(r);
		end
		return tab;
	endfunction

	localparam recip_tab_t RECIP_TAB = recip_table();

endpackage

// File: rtl/core/tws_front.sv
// Front end: tap count register, sample window, waveform counter and
// flush sequencer; issues one job per result into stage 1.
// Depends on tws_pkg.
module tws_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             adv,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  logic signed [tws_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                             last_sample,
	input  logic                             tap_count_we,
	input  logic [tws_pkg::TAP_W-1:0]        tap_count,
	output logic                             valid_s1,
	output tws_pkg::ctrl_t                   ctrl_s1,
	output tws_pkg::win_t                    win_s1
);

	logic [tws_pkg::TAP_W-1:0]  taps_q;
	logic [tws_pkg::CNT_W-1:0]  seen_q;
	logic [tws_pkg::HALF_W-1:0] flush_q;
	tws_pkg::win_t              window_q;
	tws_pkg::win_t              window_new;

	logic [tws_pkg::NSEL_W-1:0] n_eff;
	logic [tws_pkg::HALF_W-1:0] h;
	logic [tws_pkg::HALF_W-1:0] held;
	logic [tws_pkg::CNT_W-1:0]  seen_new;
	logic                       accept;
	logic                       regular;
	logic                       at_edge;

	always_comb begin
		if (taps_q == '0)
			n_eff = tws_pkg::NSEL_W'(1);
		else if (int'(taps_q) > tws_pkg::MAX_TAPS)
			n_eff = tws_pkg::NSEL_W'(tws_pkg::MAX_TAPS);
		else
			n_eff = tws_pkg::NSEL_W'(taps_q);
		h = tws_pkg::HALF_W'(n_eff >> 1);
		seen_new = (int'(seen_q) < tws_pkg::COUNT_LIMIT) ? seen_q + 1'b1 : seen_q;
		regular = seen_new > tws_pkg::CNT_W'(h);
		at_edge = seen_new < tws_pkg::CNT_W'({h, 1'b1});
		held = (seen_new < tws_pkg::CNT_W'(h)) ? tws_pkg::HALF_W'(seen_new) : h;
		window_new[0] = sample;
		for (int i = 1; i < tws_pkg::MAX_TAPS; i++)
			window_new[i] = window_q[i-1];
	end

	assign sample_ready = adv && (flush_q == '0);
	assign accept       = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q   <= tws_pkg::TAP_W'(1);
			seen_q   <= '0;
			flush_q  <= '0;
			valid_s1 <= 1'b0;
			for (int i = 0; i < tws_pkg::MAX_TAPS; i++)
				window_q[i] <= '0;
		end else begin
			if (tap_count_we)
				taps_q <= tap_count;
			if (adv) begin
				if (accept) begin
					window_q <= window_new;
					valid_s1 <= regular;
					if (last_sample) begin
						seen_q  <= '0;
						flush_q <= held;
					end else begin
						seen_q <= seen_new;
					end
				end else if (flush_q != '0) begin
					valid_s1 <= 1'b1;
					flush_q  <= flush_q - 1'b1;
				end else begin
					valid_s1 <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (accept) begin
				win_s1           <= window_new;
				ctrl_s1.smooth   <= !at_edge;
				ctrl_s1.edge_raw <= at_edge;
				ctrl_s1.last     <= last_sample && (h == '0);
				ctrl_s1.raw      <= window_new[tws_pkg::IDX_W'(h)];
				ctrl_s1.taps     <= n_eff;
			end else begin
				ctrl_s1.smooth   <= 1'b0;
				ctrl_s1.edge_raw <= 1'b1;
				ctrl_s1.last     <= (flush_q == tws_pkg::HALF_W'(1));
				ctrl_s1.raw      <= window_q[tws_pkg::IDX_W'(flush_q - 1'b1)];
				ctrl_s1.taps     <= n_eff;
			end
		end
	end

endmodule

// File: rtl/core/tws_mac.sv
// Weighted sum: tap products in stage 2, group sums in stage 3 and the
// full sum in stage 4.
// Depends on tws_pkg.
module tws_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  logic                                valid_s1,
	input  tws_pkg::ctrl_t                      ctrl_s1,
	input  tws_pkg::win_t                       win_s1,
	output logic                                valid_s4,
	output tws_pkg::ctrl_t                      ctrl_s4,
	output logic signed [tws_pkg::SUM_W-1:0]    sum_s4
);

	logic signed [tws_pkg::PROD_W-1:0] prod_d  [tws_pkg::MAX_TAPS];
	logic signed [tws_pkg::PROD_W-1:0] prod_s2 [tws_pkg::MAX_TAPS];
	logic signed [tws_pkg::SUM_W-1:0]  part_d  [tws_pkg::GROUPS];
	logic signed [tws_pkg::SUM_W-1:0]  part_s3 [tws_pkg::GROUPS];
	logic signed [tws_pkg::SUM_W-1:0]  total_d;
	logic [tws_pkg::WGT_W-1:0]         wgt;
	tws_pkg::ctrl_t                    ctrl_s2;
	tws_pkg::ctrl_t                    ctrl_s3;
	logic                              valid_s2;
	logic                              valid_s3;

	always_comb begin
		wgt = '0;
		for (int p = 0; p < tws_pkg::MAX_TAPS; p++) begin
			wgt = tws_pkg::tap_weight(p, ctrl_s1.taps);
			prod_d[p] = tws_pkg::PROD_W'(win_s1[p])
				* $signed({{(tws_pkg::PROD_W - tws_pkg::WGT_W){1'b0}}, wgt});
		end
		for (int g = 0; g < tws_pkg::GROUPS; g++) begin
			part_d[g] = '0;
			for (int k = 0; k < tws_pkg::GRP; k++)
				if (g * tws_pkg::GRP + k < tws_pkg::MAX_TAPS)
					part_d[g] = part_d[g]
						+ tws_pkg::SUM_W'(prod_s2[g * tws_pkg::GRP + k]);
		end
		total_d = '0;
		for (int g = 0; g < tws_pkg::GROUPS; g++)
			total_d = total_d + part_s3[g];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= prod_d;
			ctrl_s2 <= ctrl_s1;
			part_s3 <= part_d;
			ctrl_s3 <= ctrl_s2;
			sum_s4  <= total_d;
			ctrl_s4 <= ctrl_s3;
		end
	end

endmodule

// File: rtl/core/tws_div.sv
// Rounded division by the weight sum: numerator and reciprocal in stage 5,
// quotient estimate in stage 6, back-multiply in stage 7, correction and
// result register in stage 8.
// Depends on tws_pkg.
module tws_div (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  logic                                   valid_s4,
	input  tws_pkg::ctrl_t                         ctrl_s4,
	input  logic signed [tws_pkg::SUM_W-1:0]       sum_s4,
	output logic                                   result_valid,
	output logic signed [tws_pkg::SAMPLE_BITS-1:0] smoothed,
	output logic                                   edge_raw,
	output logic                                   last_out
);

	logic [tws_pkg::WSUM_W-1:0]       wsum;
	logic signed [tws_pkg::SUM_W-1:0] abs_sum;
	logic [tws_pkg::MAG_W-1:0]        mag;
	logic [tws_pkg::MUL_W-1:0]        mul;
	logic [tws_pkg::NUM_W-1:0]        rem;
	logic [tws_pkg::Q_W-1:0]          qf;
	logic [tws_pkg::Q_W-1:0]          qs;

	logic                       valid_s5, valid_s6, valid_s7;
	tws_pkg::ctrl_t             ctrl_s5, ctrl_s6, ctrl_s7;
	logic                       neg_s5, neg_s6, neg_s7;
	logic [tws_pkg::NUM_W-1:0]  num_s5, num_s6, num_s7;
	logic [tws_pkg::DIV_W-1:0]  dv_s5, dv_s6, dv_s7;
	logic [tws_pkg::RCP_W-1:0]  rcp_s5;
	logic [tws_pkg::Q_W-1:0]    q0_s6, q0_s7;
	logic [tws_pkg::NUM_W-1:0]  qd_s7;

	always_comb begin
		wsum    = tws_pkg::wsum_of(ctrl_s4.taps);
		abs_sum = (sum_s4 < 0) ? -sum_s4 : sum_s4;
		mag     = tws_pkg::MAG_W'(abs_sum);
		mul     = tws_pkg::MUL_W'(num_s5) * tws_pkg::MUL_W'(rcp_s5);
		rem     = num_s7 - qd_s7;
		qf      = q0_s7 + tws_pkg::Q_W'(rem >= tws_pkg::NUM_W'(dv_s7));
		qs      = neg_s7 ? -qf : qf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5     <= 1'b0;
			valid_s6     <= 1'b0;
			valid_s7     <= 1'b0;
			result_valid <= 1'b0;
		end else if (adv) begin
			valid_s5     <= valid_s4;
			valid_s6     <= valid_s5;
			valid_s7     <= valid_s6;
			result_valid <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctrl_s5 <= ctrl_s4;
			neg_s5  <= sum_s4 < 0;
			num_s5  <= (tws_pkg::NUM_W'(mag) << 1) + tws_pkg::NUM_W'(wsum);
			dv_s5   <= tws_pkg::DIV_W'({wsum, 1'b0});
			rcp_s5  <= tws_pkg::RECIP_TAB[ctrl_s4.taps];

			ctrl_s6 <= ctrl_s5;
			neg_s6  <= neg_s5;
			num_s6  <= num_s5;
			dv_s6   <= dv_s5;
			q0_s6   <= mul[tws_pkg::RCP_SHIFT +: tws_pkg::Q_W];

			ctrl_s7 <= ctrl_s6;
			neg_s7  <= neg_s6;
			num_s7  <= num_s6;
			dv_s7   <= dv_s6;
			q0_s7   <= q0_s6;
			qd_s7   <= tws_pkg::NUM_W'(q0_s6) * tws_pkg::NUM_W'(dv_s6);

			smoothed <= ctrl_s7.smooth ? $signed(qs) : $signed(ctrl_s7.raw);
			edge_raw <= ctrl_s7.edge_raw;
			last_out <= ctrl_s7.last;
		end
	end

endmodule

// File: rtl/core/triangle_weighted_smoother.sv
// Top level of the triangle-weighted smoother: front end, weighted sum and
// divider pipeline under one stall enable.
// Depends on tws_pkg, tws_front, tws_mac, tws_div.
//
//   channel   handshake                     payload
//   sample    sample_valid / sample_ready   sample, last_sample
//   result    result_valid / result_ready   smoothed, edge_raw, last_out
//   config    tap_count_we                  tap_count
//
// One sample per cycle while the pipeline advances and no flush is pending;
// eight register stages, from stage 1 to the result register.
// A final sample with held samples keeps sample_ready low while the front
// end replays them.
// A stalled result freezes every stage, so nothing is lost or repeated.
// Reset clears valid bits, counters, the window and sets tap_count to 1.
module triangle_weighted_smoother (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  logic signed [tws_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   last_sample,
	input  logic                                   tap_count_we,
	input  logic [tws_pkg::TAP_W-1:0]              tap_count,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic signed [tws_pkg::SAMPLE_BITS-1:0] smoothed,
	output logic                                   edge_raw,
	output logic                                   last_out
);

	logic                             adv;
	logic                             valid_s1;
	tws_pkg::ctrl_t                   ctrl_s1;
	tws_pkg::win_t                    win_s1;
	logic                             valid_s4;
	tws_pkg::ctrl_t                   ctrl_s4;
	logic signed [tws_pkg::SUM_W-1:0] sum_s4;

	assign adv = !result_valid || result_ready;

	tws_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.last_sample  (last_sample),
		.tap_count_we (tap_count_we),
		.tap_count    (tap_count),
		.valid_s1     (valid_s1),
		.ctrl_s1      (ctrl_s1),
		.win_s1       (win_s1)
	);

	tws_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.ctrl_s1  (ctrl_s1),
		.win_s1   (win_s1),
		.valid_s4 (valid_s4),
		.ctrl_s4  (ctrl_s4),
		.sum_s4   (sum_s4)
	);

	tws_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.valid_s4     (valid_s4),
		.ctrl_s4      (ctrl_s4),
		.sum_s4       (sum_s4),
		.result_valid (result_valid),
		.smoothed     (smoothed),
		.edge_raw     (edge_raw),
		.last_out     (last_out)
	);

endmodule

// File: rtl/core/tws_checker.sv
// Port-level checks for the triangle-weighted smoother, bound to the top.
// Depends on tws_pkg and triangle_weighted_smoother.
module tws_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   sample_ready,
	input logic                                   result_valid,
	input logic                                   result_ready,
	input logic signed [tws_pkg::SAMPLE_BITS-1:0] smoothed,
	input logic                                   edge_raw,
	input logic                                   last_out
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result request dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			$stable(smoothed) && $stable(edge_raw) && $stable(last_out))
		else $error("result payload changed while stalled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !sample_ready)
		else $error("sample request taken while result stalled");

	a_reset_clears: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result request during reset");

endmodule

bind triangle_weighted_smoother tws_checker u_chk (.*);

// File: dv/testbench.sv
// Self-checking bench for triangle_weighted_smoother: sample requests from a queue,
// an in-bench triangular FIR predictor, and an in-order result checker.
// Depends on tws_pkg and the triangle_weighted_smoother RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE = 20;
	localparam int PHASE_ITEMS = 28;
	localparam int NUM_PHASES = 13;

	typedef struct {
		logic signed [tws_pkg::SAMPLE_BITS-1:0] value;
		logic                                   last;
	} sample_req_t;

	typedef struct {
		logic signed [tws_pkg::SAMPLE_BITS-1:0] value;
		logic                                   edge_raw;
		logic                                   last;
	} smooth_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [tws_pkg::SAMPLE_BITS-1:0] sample = '0;
	logic last_sample = 1'b0;
	logic tap_count_we = 1'b0;
	logic [tws_pkg::TAP_W-1:0] tap_count = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [tws_pkg::SAMPLE_BITS-1:0] smoothed;
	logic edge_raw;
	logic last_out;

	sample_req_t sample_q[$];
	smooth_out_t expected_q[$];
	sample_req_t drv_req;

	tws_pkg::win_t hist = '{default: '0};
	int unsigned seen_cnt = 0;
	logic [tws_pkg::TAP_W-1:0] taps_cfg = tws_pkg::TAP_W'(1);

	int unsigned send_idle_pct = 32;
	int unsigned recv_idle_pct = 48;
	int unsigned err_count = 0;
	int unsigned cycle_cnt = 0;

	int tap_list[NUM_PHASES] = '{16, 5, 4, 31, 2, 7, 0, 12, 17, 9, 16, 3, 8};

	triangle_weighted_smoother i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.last_sample (last_sample),
		.tap_count_we(tap_count_we),
		.tap_count   (tap_count),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.smoothed    (smoothed),
		.edge_raw    (edge_raw),
		.last_out    (last_out)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned taps_in_use(logic [tws_pkg::TAP_W-1:0] t);
		if (t == 0)
			return 1;
		if (t > tws_pkg::MAX_TAPS)
			return tws_pkg::MAX_TAPS;
		return t;
	endfunction

	function automatic logic signed [tws_pkg::SAMPLE_BITS-1:0] tri_average(
		int unsigned n);
		int unsigned h;
		int unsigned w;
		longint acc;
		longint wsum;
		longint mag;
		longint q;
		h = n / 2;
		wsum = (n % 2 == 1) ? longint'((h + 1) * (h + 1)) : longint'(h * (h + 1));
		acc = 0;
		for (int unsigned p = 0; p < n; p++) begin
			w = (p + 1 < n - p) ? p + 1 : n - p;
			acc += longint'(w) * longint'(hist[p]);
		end
		mag = (acc < 0) ? -acc : acc;
		q = (2 * mag + wsum) / (2 * wsum);
		return tws_pkg::SAMPLE_BITS'((acc < 0) ? -q : q);
	endfunction

	task automatic predict_smoothing(
		input logic signed [tws_pkg::SAMPLE_BITS-1:0] s, input logic fin);
		int unsigned n;
		int unsigned h;
		int unsigned held;
		smooth_out_t r;
		n = taps_in_use(taps_cfg);
		h = n / 2;
		for (int i = tws_pkg::MAX_TAPS - 1; i > 0; i--)
			hist[i] = hist[i-1];
		hist[0] = s;
		if (seen_cnt < tws_pkg::COUNT_LIMIT)
			seen_cnt++;
		if (seen_cnt > h) begin
			r.edge_raw = (seen_cnt < 2 * h + 1);
			r.value = r.edge_raw ? hist[h] : tri_average(n);
			r.last = fin && (h == 0);
			expected_q.insert(expected_q.size(), r);
		end
		if (fin) begin
			held = (seen_cnt < h) ? seen_cnt : h;
			for (int unsigned p = held; p > 0; p--) begin
				r.value = hist[p-1];
				r.edge_raw = 1'b1;
				r.last = (p == 1);
				expected_q.insert(expected_q.size(), r);
			end
			seen_cnt = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	task automatic check_result();
		smooth_out_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("unrequested result", smoothed, 0);
		end else begin
			want = expected_q.pop_front();
			if (smoothed !== want.value)
				report_mismatch("smoothed", smoothed, want.value);
			if (edge_raw !== want.edge_raw)
				report_mismatch("edge_raw", edge_raw, want.edge_raw);
			if (last_out !== want.last)
				report_mismatch("last_out", last_out, want.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && sample_ready)
				predict_smoothing(sample, last_sample);
			if (!sample_valid || sample_ready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_req = sample_q.pop_front();
					sample <= drv_req.value;
					last_sample <= drv_req.last;
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready)
				check_result();
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("triangle_weighted_smoother verification failed");
			$finish;
		end
	end

	task automatic push_request(input logic signed [tws_pkg::SAMPLE_BITS-1:0] v, input logic fin);
		sample_req_t r;
		r.value = v;
		r.last = fin;
		sample_q.insert(sample_q.size(), r);
	endtask

	// hold the feed until every request is taken and every result is back
	task automatic drain_block();
		@(negedge clk);
		while (sample_q.size() != 0 || sample_valid || expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_taps(input int v);
		@(posedge clk);
		tap_count_we <= 1'b1;
		tap_count <= tws_pkg::TAP_W'(v);
		taps_cfg = tws_pkg::TAP_W'(v);
		@(posedge clk);
		tap_count_we <= 1'b0;
	endtask

	task automatic push_waveform(input int len, input bit close);
		int style;
		logic signed [tws_pkg::SAMPLE_BITS-1:0] v;
		style = $urandom_range(5);
		for (int i = 0; i < len; i++) begin
			case (style)
				0: v = tws_pkg::SAMPLE_BITS'($signed($urandom_range(16)) - 8);
				1: v = 16'sh7fff;
				2: v = -16'sh8000;
				3: v = (i % 2 == 0) ? 16'sh7fff : -16'sh8000;
				default: v = tws_pkg::SAMPLE_BITS'($urandom);
			endcase
			push_request(v, close && (i == len - 1));
		end
	endtask

	initial begin
		int unsigned n;
		int unsigned h;
		int cnt;
		int len;
		int kind;
		bit close;
		bit paused;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset tap count: plain pass-through
		push_request(16'sh7fff, 1'b0);
		push_request(-16'sh8000, 1'b1);
		push_request(16'sh0000, 1'b1);
		drain_block();
		write_taps(3);
		push_request(16'sh7fff, 1'b0);
		push_request(-16'sh8000, 1'b0);
		push_request(16'sh7fff, 1'b0);
		push_request(-16'sh8000, 1'b0);
		push_request(16'sh0001, 1'b1);
		push_request(16'sh0005, 1'b0);
		push_request(-16'sh0005, 1'b1);
		drain_block();
		// even taps: rounding ties
		write_taps(2);
		push_request(16'sh0001, 1'b0);
		push_request(16'sh0000, 1'b0);
		push_request(-16'sh0001, 1'b0);
		push_request(16'sh0000, 1'b0);
		push_request(16'sh0003, 1'b1);
		drain_block();
		write_taps(0);
		push_request(-16'sh8000, 1'b1);

		paused = 1'b0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain_block();
			if (ph < 5) begin
				send_idle_pct = 32;
				recv_idle_pct = 48;
			end else if (ph < 9) begin
				send_idle_pct = 48;
				recv_idle_pct = 32;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_taps(tap_list[ph]);
			n = taps_in_use(tws_pkg::TAP_W'(tap_list[ph]));
			h = n / 2;
			cnt = 0;
			while (cnt < PHASE_ITEMS) begin
				kind = $urandom_range(9);
				if (kind == 0)
					len = $urandom_range((h > 0) ? 2 * h : 1, 1);
				else if (kind == 1)
					len = $urandom_range(40, 32);
				else
					len = $urandom_range(2 * h + 12, 2 * h + 1);
				// leave the waveform open so the next tap count lands mid-stream
				close = !((cnt + len >= PHASE_ITEMS) && (ph == 2 || $urandom_range(3) == 0));
				push_waveform(len, close);
				cnt += len;
				if (ph == 4 && !paused && cnt >= PHASE_ITEMS / 2) begin
					drain_block();
					paused = 1'b1;
				end
			end
		end

		drain_block();
		if (err_count == 0)
			$display("triangle_weighted_smoother verification clean");
		else
			$display("triangle_weighted_smoother verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/tws_pkg.sv
rtl/core/tws_front.sv
rtl/core/tws_mac.sv
rtl/core/tws_div.sv
rtl/core/triangle_weighted_smoother.sv
rtl/core/tws_checker.sv
dv/testbench.sv
